/* hw/rtl/wspr_pkg.sv */
package wspr_pkg;

  localparam int unsigned FaultW   = 32;
  localparam int unsigned UsW      = 20;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned ProdW    = FaultW + UsW;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [UsW-1:0] US_PER_SECOND = 20'd1000000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LOW_WATER       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_WATER      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ADJUST_INTERVAL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_FAULT_RATE  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MIN_FAULT_RATE  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GROW_STEP       = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SHRINK_STEP     = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SCAN_QUANTUM    = 3'd7;

  // frame states
  localparam logic [2:0] ST_NONE          = 3'd0;
  localparam logic [2:0] ST_ACTIVE        = 3'd1;
  localparam logic [2:0] ST_INACTIVE      = 3'd2;
  localparam logic [2:0] ST_BUSY          = 3'd3;
  localparam logic [2:0] ST_WIRED         = 3'd4;
  localparam logic [2:0] ST_MODIFIED      = 3'd5;
  localparam logic [2:0] ST_MODIFIED_TEMP = 3'd6;

  // page actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_UNMAP = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // pte flag bits
  localparam int unsigned PTE_PRESENT  = 0;
  localparam int unsigned PTE_ACCESSED = 1;
  localparam int unsigned PTE_MODIFIED = 2;
  localparam int unsigned PTE_REQUERY  = 3;

  typedef struct packed {
    logic             mode;
    logic [31:0]      mapped_pages;
    logic [31:0]      fault_total;
    logic [TimeW-1:0] elapsed_us;
    logic [31:0]      working_set;
    logic [31:0]      working_set_min;
    logic [31:0]      working_set_max;
    logic [31:0]      free_pages;
    logic [3:0]       pte_flags;
    logic [2:0]       frame_state;
    logic             last_reference;
    logic             cache_temporary;
  } wspr_in_t;

  typedef struct packed {
    logic [31:0] working_set_out;
    logic        adjusted;
    logic        trimming;
    logic [31:0] target_left;
    logic [1:0]  page_action;
    logic [2:0]  new_frame_state;
    logic        scan_done;
  } wspr_out_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] new_state;
    logic       counted;
    logic       take_target;
  } wspr_page_res_t;

endpackage

/* hw/rtl/wspr_div.sv */
module wspr_div
  import wspr_pkg::*;
#(
  parameter int unsigned DividendW = 52,
  parameter int unsigned DivisorW  = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DividendW);

  logic                 busy_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic [DivisorW:0]    rem_q;
  logic [DividendW-1:0] quo_q;
  logic [DivisorW-1:0]  dvs_q;

  logic [DivisorW:0]    rem_sh;
  logic [DivisorW:0]    diff;
  logic                 ge;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  assign rem_sh = {rem_q[DivisorW-1:0], quo_q[DividendW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DividendW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff : rem_sh;
      quo_q <= {quo_q[DividendW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* hw/rtl/wspr_page_dec.sv */
module wspr_page_dec
  import wspr_pkg::*;
(
  input  logic [3:0]     pte_flags_i,
  input  logic [2:0]     frame_state_i,
  input  logic           last_reference_i,
  input  logic           cache_temporary_i,
  input  logic           quantum_nz_i,
  input  logic           target_nz_i,
  output wspr_page_res_t res_o
);

  logic       skip_st;
  logic       modified;
  logic [2:0] st;

  assign skip_st = (frame_state_i == ST_NONE) || (frame_state_i == ST_BUSY) ||
                   (frame_state_i == ST_WIRED) || (frame_state_i > ST_MODIFIED_TEMP);

  always_comb begin
    res_o.action      = ACT_NONE;
    res_o.new_state   = frame_state_i;
    res_o.counted     = 1'b0;
    res_o.take_target = 1'b0;
    modified          = pte_flags_i[PTE_MODIFIED];
    st                = frame_state_i;
    if (quantum_nz_i && pte_flags_i[PTE_PRESENT] && !skip_st) begin
      if (target_nz_i) begin
        if (!pte_flags_i[PTE_ACCESSED] && (st == ST_ACTIVE)) begin
          res_o.action = ACT_UNMAP;
          // dirty bit seen again after unmap
          if (pte_flags_i[PTE_REQUERY]) begin
            modified = 1'b1;
          end
          if (last_reference_i) begin
            st                = ST_INACTIVE;
            res_o.take_target = 1'b1;
          end
        end else if (pte_flags_i[PTE_ACCESSED]) begin
          res_o.action = ACT_CLEAR;
        end
      end
      if (modified && ((st == ST_ACTIVE) || (st == ST_INACTIVE))) begin
        st = cache_temporary_i ? ST_MODIFIED_TEMP : ST_MODIFIED;
      end
      res_o.new_state = st;
      res_o.counted   = 1'b1;
    end
  end

endmodule

/* hw/rtl/working_set_page_reclaim_policy_unit.sv */
// channel  | valid      | stall       | payload
// in       | in_valid_i | in_stall_o  | in_data_i  (wspr_in_t)
// out      | out_valid_o| out_stall_i | out_data_o (wspr_out_t)
// cfg      | cfg_we_i   | -           | cfg_idx_i, cfg_data_i
//
// one item at a time; a page item is decoded in S_PAGE, its result registered once the output is free
// a start item runs S_MUL then S_FIN, with S_DSTART to S_ADJ between when the adjust interval has passed:
// the fault rate goes through a 52-step shift-subtract divider
// the result sits in an output register, so the next item is taken while it waits
// asynchronous active-low reset; config registers reset to their defaults
module working_set_page_reclaim_policy_unit
  import wspr_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wspr_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wspr_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // rate compare width: the saturated rate against 32-bit thresholds
  localparam int unsigned CmpW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_MUL    = 8'b00000010,
    S_DSTART = 8'b00000100,
    S_DWAIT  = 8'b00001000,
    S_SAT    = 8'b00010000,
    S_ADJ    = 8'b00100000,
    S_FIN    = 8'b01000000,
    S_PAGE   = 8'b10000000
  } wspr_state_e;

  wspr_state_e state_q, state_d;

  // configuration
  logic [31:0]    low_water_q;
  logic [31:0]    high_water_q;
  logic [TimeW-1:0] adjust_interval_q;
  logic [31:0]    max_fault_rate_q;
  logic [31:0]    min_fault_rate_q;
  logic [31:0]    grow_step_q;
  logic [31:0]    shrink_step_q;
  logic [15:0]    scan_quantum_q;

  // architectural state
  logic           trim_q;
  logic [31:0]    target_q;
  logic [15:0]    quantum_q;

  // item datapath
  wspr_in_t             item_q;
  logic [31:0]          ws_q;
  logic [ProdW-1:0]     prod_q;
  logic [COUNT_WIDTH-1:0] rate_q;
  logic                 adj_q;

  // result
  wspr_out_t out_q, out_d;
  logic      out_valid_q;
  logic      out_free;
  logic      load;

  logic                   adj_d;
  logic                   div_start;
  logic                   div_done;
  logic [ProdW-1:0]       div_quot;
  logic [COUNT_WIDTH-1:0] rate_sat;
  logic [CmpW-1:0]        rate_ext;
  logic                   grow_ok;
  logic                   shrink_ok;
  logic [32:0]            grow_sum;
  logic [31:0]            ws_adj;
  logic                   trim_d;
  logic [31:0]            target_d;
  logic [15:0]            quantum_d;
  logic                   page_done;
  wspr_page_res_t         page_res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // fault rate divider, fed by the registered product
  wspr_div #(
    .DividendW(ProdW),
    .DivisorW (TimeW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q),
    .divisor_i (item_q.elapsed_us),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // saturate the quotient to the count width
  if (COUNT_WIDTH >= ProdW) begin : g_no_sat
    assign rate_sat = COUNT_WIDTH'(div_quot);
  end else begin : g_sat
    assign rate_sat = (div_quot[ProdW-1:COUNT_WIDTH] != '0) ? '1
                                                            : div_quot[COUNT_WIDTH-1:0];
  end

  // working set adjustment, from the registered rate
  assign rate_ext  = CmpW'(rate_q);
  assign grow_ok   = (rate_ext > CmpW'(max_fault_rate_q)) &&
                     (item_q.mapped_pages >= ws_q) && (ws_q < item_q.working_set_max);
  assign shrink_ok = (rate_ext < CmpW'(min_fault_rate_q)) &&
                     (item_q.mapped_pages <= ws_q) && (ws_q > item_q.working_set_min);
  assign grow_sum  = {1'b0, ws_q} + {1'b0, grow_step_q};

  always_comb begin
    ws_adj = ws_q;
    if (grow_ok) begin
      ws_adj = grow_sum[32] ? '1 : grow_sum[31:0];
    end else if (shrink_ok) begin
      ws_adj = (ws_q > shrink_step_q) ? (ws_q - shrink_step_q) : '0;
    end
  end

  // page decision
  wspr_page_dec u_page_dec (
    .pte_flags_i      (item_q.pte_flags),
    .frame_state_i    (item_q.frame_state),
    .last_reference_i (item_q.last_reference),
    .cache_temporary_i(item_q.cache_temporary),
    .quantum_nz_i     (quantum_q != '0),
    .target_nz_i      (target_q != '0),
    .res_o            (page_res)
  );

  // hysteresis on free pages; only takes effect when a start item finishes
  always_comb begin
    trim_d = trim_q;
    if (!trim_q && (item_q.free_pages < low_water_q)) begin
      trim_d = 1'b1;
    end else if (trim_q && (item_q.free_pages > high_water_q)) begin
      trim_d = 1'b0;
    end
  end

  assign adj_d     = item_q.elapsed_us > adjust_interval_q;
  assign page_done = (quantum_q == '0) ? 1'b1
                   : (page_res.counted ? (quantum_q == 16'd1) : 1'b0);

  // sequencer and result
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    load      = 1'b0;
    out_d     = out_q;
    target_d  = target_q;
    quantum_d = quantum_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = in_data_i.mode ? S_PAGE : S_MUL;
        end
      end
      S_MUL: begin
        state_d = adj_d ? S_DSTART : S_FIN;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        state_d = S_ADJ;
      end
      S_ADJ: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        target_d  = (trim_d && (item_q.mapped_pages > ws_q)) ?
                    (item_q.mapped_pages - ws_q) : '0;
        quantum_d = scan_quantum_q;
        if (out_free) begin
          load                  = 1'b1;
          out_d.working_set_out = ws_q;
          out_d.adjusted        = adj_q;
          out_d.trimming        = trim_d;
          out_d.target_left     = target_d;
          out_d.page_action     = ACT_NONE;
          out_d.new_frame_state = ST_NONE;
          out_d.scan_done       = (scan_quantum_q == '0);
          state_d               = S_IDLE;
        end
      end
      S_PAGE: begin
        if (page_res.take_target) begin
          target_d = target_q - 32'd1;
        end
        if (page_res.counted) begin
          quantum_d = quantum_q - 16'd1;
        end
        if (out_free) begin
          load                  = 1'b1;
          out_d.working_set_out = '0;
          out_d.adjusted        = 1'b0;
          out_d.trimming        = trim_q;
          out_d.target_left     = target_d;
          out_d.page_action     = page_res.action;
          out_d.new_frame_state = page_res.new_state;
          out_d.scan_done       = page_done;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      trim_q      <= 1'b0;
      target_q    <= '0;
      quantum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
        target_q    <= target_d;
        quantum_q   <= quantum_d;
        if (state_q == S_FIN) begin
          trim_q <= trim_d;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_water_q       <= 32'd8192;
      high_water_q      <= 32'd16384;
      adjust_interval_q <= 48'd1000000;
      max_fault_rate_q  <= 32'd1000;
      min_fault_rate_q  <= 32'd100;
      grow_step_q       <= 32'd16;
      shrink_step_q     <= 32'd16;
      scan_quantum_q    <= 16'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOW_WATER:       low_water_q       <= cfg_data_i[31:0];
        CFG_HIGH_WATER:      high_water_q      <= cfg_data_i[31:0];
        CFG_ADJUST_INTERVAL: adjust_interval_q <= cfg_data_i[TimeW-1:0];
        CFG_MAX_FAULT_RATE:  max_fault_rate_q  <= cfg_data_i[31:0];
        CFG_MIN_FAULT_RATE:  min_fault_rate_q  <= cfg_data_i[31:0];
        CFG_GROW_STEP:       grow_step_q       <= cfg_data_i[31:0];
        CFG_SHRINK_STEP:     shrink_step_q     <= cfg_data_i[31:0];
        CFG_SCAN_QUANTUM:    scan_quantum_q    <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      item_q <= in_data_i;
      ws_q   <= in_data_i.working_set;
    end
    if (state_q == S_MUL) begin
      // 32 x 20 product, one multiply per start item
      prod_q <= {{UsW{1'b0}}, item_q.fault_total} * {{FaultW{1'b0}}, US_PER_SECOND};
      adj_q  <= adj_d;
    end
    if (state_q == S_SAT) begin
      rate_q <= rate_sat;
    end
    if (state_q == S_ADJ) begin
      ws_q <= ws_adj;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* dv/tb_working_set_page_reclaim_policy_unit.sv */
`timescale 1ns / 100ps

module tb_working_set_page_reclaim_policy_unit
  import wspr_pkg::*;
();

  localparam int unsigned CountW        = 32;
  localparam logic [63:0] RateMax       = (64'd1 << CountW) - 64'd1;
  localparam logic        MODE_START    = 1'b0;
  localparam logic        MODE_PAGE     = 1'b1;
  localparam logic [2:0]  ST_UNUSED     = 3'd7;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 100;
  localparam int unsigned PhaseItems    = 140;
  localparam int unsigned NumPhases     = 6;

  // scoreboard: own copy of the policy state and registers, one expected beat per item
  class reclaim_scoreboard;
    logic [31:0] low_water;
    logic [31:0] high_water;
    logic [47:0] adjust_interval;
    logic [31:0] max_rate;
    logic [31:0] min_rate;
    logic [31:0] grow_step;
    logic [31:0] shrink_step;
    logic [15:0] scan_quantum;

    logic        trimming;
    logic [31:0] target_pages;
    logic [15:0] quantum_left;

    wspr_out_t   pending_decisions[$];
    int unsigned n_errors;
    int unsigned n_checked;

    function new();
      low_water       = 32'd8192;
      high_water      = 32'd16384;
      adjust_interval = 48'd1000000;
      max_rate        = 32'd1000;
      min_rate        = 32'd100;
      grow_step       = 32'd16;
      shrink_step     = 32'd16;
      scan_quantum    = 16'd1024;
      trimming        = 1'b0;
      target_pages    = '0;
      quantum_left    = '0;
      n_errors        = 0;
      n_checked       = 0;
    endfunction

    function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
      case (idx)
        CFG_LOW_WATER:       low_water       = value[31:0];
        CFG_HIGH_WATER:      high_water      = value[31:0];
        CFG_ADJUST_INTERVAL: adjust_interval = value[47:0];
        CFG_MAX_FAULT_RATE:  max_rate        = value[31:0];
        CFG_MIN_FAULT_RATE:  min_rate        = value[31:0];
        CFG_GROW_STEP:       grow_step       = value[31:0];
        CFG_SHRINK_STEP:     shrink_step     = value[31:0];
        CFG_SCAN_QUANTUM:    scan_quantum    = value[15:0];
        default: ;
      endcase
    endfunction

    function wspr_out_t reclaim_decision(input wspr_in_t it);
      wspr_out_t   res;
      logic [63:0] product;
      logic [63:0] rate;
      logic [32:0] grown;
      logic [31:0] ws;
      logic [2:0]  st;
      logic [1:0]  act;
      logic        modified;
      res = '0;
      if (it.mode == MODE_START) begin
        ws = it.working_set;
        if (it.elapsed_us > adjust_interval) begin
          product = 64'(it.fault_total) * 64'(US_PER_SECOND);
          rate    = product / 64'(it.elapsed_us);
          if (rate > RateMax) rate = RateMax;
          res.adjusted = 1'b1;
          if (rate > 64'(max_rate) && it.mapped_pages >= ws && ws < it.working_set_max) begin
            grown = 33'(ws) + 33'(grow_step);
            ws    = grown[32] ? '1 : grown[31:0];
          end else if (rate < 64'(min_rate) && it.mapped_pages <= ws &&
                       ws > it.working_set_min) begin
            ws = (ws > shrink_step) ? ws - shrink_step : '0;
          end
        end
        // free-page hysteresis on the global flag
        if (!trimming && it.free_pages < low_water) trimming = 1'b1;
        else if (trimming && it.free_pages > high_water) trimming = 1'b0;
        target_pages = (trimming && it.mapped_pages > ws) ? it.mapped_pages - ws : '0;
        quantum_left = scan_quantum;
        res.working_set_out = ws;
        res.trimming        = trimming;
        res.target_left     = target_pages;
        res.scan_done       = (quantum_left == 0);
        return res;
      end
      st = it.frame_state;
      res.trimming        = trimming;
      res.target_left     = target_pages;
      res.new_frame_state = st;
      res.page_action     = ACT_NONE;
      if (quantum_left == 0) begin
        res.scan_done = 1'b1;
        return res;
      end
      if (!it.pte_flags[PTE_PRESENT] || st == ST_NONE || st == ST_BUSY ||
          st == ST_WIRED || st == ST_UNUSED) begin
        return res;
      end
      act      = ACT_NONE;
      modified = it.pte_flags[PTE_MODIFIED];
      if (target_pages != 0) begin
        if (!it.pte_flags[PTE_ACCESSED] && st == ST_ACTIVE) begin
          act = ACT_UNMAP;
          if (it.pte_flags[PTE_REQUERY]) modified = 1'b1;
          if (it.last_reference) begin
            st           = ST_INACTIVE;
            target_pages = target_pages - 32'd1;
          end
        end else if (it.pte_flags[PTE_ACCESSED]) begin
          act = ACT_CLEAR;
        end
      end
      if (modified && (st == ST_ACTIVE || st == ST_INACTIVE))
        st = it.cache_temporary ? ST_MODIFIED_TEMP : ST_MODIFIED;
      quantum_left = quantum_left - 16'd1;
      res.page_action     = act;
      res.new_frame_state = st;
      res.target_left     = target_pages;
      res.scan_done       = (quantum_left == 0);
      return res;
    endfunction

    function void note_item(input wspr_in_t it);
      pending_decisions.push_back(reclaim_decision(it));
    endfunction

    function int unsigned pending();
      return pending_decisions.size();
    endfunction

    task report_mismatch(input string what, input logic [47:0] got, input logic [47:0] want);
      n_errors++;
      if (n_errors <= 200)
        $display("mismatch on beat %0d: %s got %0h want %0h", n_checked, what, got, want);
    endtask

    task check_decision(input wspr_out_t got);
      wspr_out_t want;
      n_checked++;
      if (pending_decisions.size() == 0) begin
        report_mismatch("result beat with nothing expected", got.target_left, '0);
        return;
      end
      want = pending_decisions.pop_front();
      if (got.working_set_out !== want.working_set_out)
        report_mismatch("working_set_out", got.working_set_out, want.working_set_out);
      if (got.adjusted !== want.adjusted)
        report_mismatch("adjusted", got.adjusted, want.adjusted);
      if (got.trimming !== want.trimming)
        report_mismatch("trimming", got.trimming, want.trimming);
      if (got.target_left !== want.target_left)
        report_mismatch("target_left", got.target_left, want.target_left);
      if (got.page_action !== want.page_action)
        report_mismatch("page_action", got.page_action, want.page_action);
      if (got.new_frame_state !== want.new_frame_state)
        report_mismatch("new_frame_state", got.new_frame_state, want.new_frame_state);
      if (got.scan_done !== want.scan_done)
        report_mismatch("scan_done", got.scan_done, want.scan_done);
    endtask
  endclass

  // dut-facing signals, the bench-driven ones known from time zero
  logic                clk;
  logic                rst_n    = 1'b0;
  logic                in_valid = 1'b0;
  wspr_in_t            in_data  = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  wspr_out_t           out_data;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // quiet switches idling off on both sides; hold_off_req asks the receiver for a long stall
  bit quiet        = 1'b0;
  bit hold_off_req = 1'b0;

  reclaim_scoreboard sb;

  working_set_page_reclaim_policy_unit #(
    .COUNT_WIDTH(CountW)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit, several times the slowest legal run
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  // result monitor: sampled at the edge, before any of this edge's updates land
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) sb.check_decision(out_data);
  end

  // receiver: short random stall bursts, plus one long hold-off on request
  initial begin
    int unsigned burst;
    int unsigned held_for;
    burst = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        for (held_for = 0; held_for < HoldOffCycles; held_for++) @(posedge clk);
        out_stall <= 1'b0;
        burst = 0;
      end else if (burst != 0) begin
        burst--;
        if (burst == 0) out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4);
        out_stall <= 1'b1;
      end
    end
  end

  // present one beat and hold it until taken; valid is left high for the caller to reuse
  task automatic send_item(input wspr_in_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(it);
  endtask

  task automatic pause(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // send with an occasional gap behind it
  task automatic offer(input wspr_in_t it);
    send_item(it);
    if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 4));
  endtask

  // stop sending and wait until every expected beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // write enable is left high here; program_policy lowers it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic program_policy(input logic [31:0] lw, input logic [31:0] hw,
                                input logic [47:0] ival, input logic [31:0] maxr,
                                input logic [31:0] minr, input logic [31:0] gs,
                                input logic [31:0] ss, input logic [15:0] quantum);
    settle();
    write_reg(CFG_LOW_WATER, 48'(lw));
    write_reg(CFG_HIGH_WATER, 48'(hw));
    write_reg(CFG_ADJUST_INTERVAL, ival);
    write_reg(CFG_MAX_FAULT_RATE, 48'(maxr));
    write_reg(CFG_MIN_FAULT_RATE, 48'(minr));
    write_reg(CFG_GROW_STEP, 48'(gs));
    write_reg(CFG_SHRINK_STEP, 48'(ss));
    write_reg(CFG_SCAN_QUANTUM, 48'(quantum));
    cfg_we <= 1'b0;
  endtask

  // unused fields of each item kind are left random so every bit toggles
  function automatic wspr_in_t rand_bits();
    logic [255:0] raw;
    for (int i = 0; i < 8; i++) raw[i*32 +: 32] = $urandom;
    return wspr_in_t'(raw[$bits(wspr_in_t)-1:0]);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[47:0];
  endfunction

  // a value a couple either side of v, wrapping at the ends
  function automatic logic [31:0] near32(input logic [31:0] v);
    return v + 32'($urandom_range(0, 4)) - 32'd2;
  endfunction

  function automatic wspr_in_t start_item(input logic [31:0] mapped, input logic [31:0] faults,
                                          input logic [47:0] elapsed, input logic [31:0] ws,
                                          input logic [31:0] wmin, input logic [31:0] wmax,
                                          input logic [31:0] free_now);
    wspr_in_t it;
    it = rand_bits();
    it.mode            = MODE_START;
    it.mapped_pages    = mapped;
    it.fault_total     = faults;
    it.elapsed_us      = elapsed;
    it.working_set     = ws;
    it.working_set_min = wmin;
    it.working_set_max = wmax;
    it.free_pages      = free_now;
    return it;
  endfunction

  function automatic wspr_in_t page_item(input logic [3:0] flags, input logic [2:0] st,
                                         input logic last_ref, input logic temp);
    wspr_in_t it;
    it = rand_bits();
    it.mode            = MODE_PAGE;
    it.pte_flags       = flags;
    it.frame_state     = st;
    it.last_reference  = last_ref;
    it.cache_temporary = temp;
    return it;
  endfunction

  // start beat aimed at the interval edge and at the fault-rate thresholds
  function automatic wspr_in_t rand_start();
    logic [48:0] sum;
    logic [47:0] el;
    logic [31:0] tgt;
    logic [95:0] aim;
    logic [31:0] faults;
    logic [31:0] ws;
    logic [31:0] mapped;
    logic [31:0] wmin;
    logic [31:0] wmax;
    logic [31:0] free_now;
    case ($urandom_range(0, 3))
      0: el = sb.adjust_interval;
      1: begin
        sum = 49'(sb.adjust_interval) + 49'($urandom_range(1, 1000000));
        el  = sum[48] ? '1 : sum[47:0];
      end
      2: el = rand48();
      default: el = 48'($urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 3))
      0, 1: begin
        tgt    = near32($urandom_range(0, 1) ? sb.max_rate : sb.min_rate);
        aim    = 96'(tgt) * 96'(el) / 96'(US_PER_SECOND);
        faults = (aim > 96'(32'hFFFF_FFFF)) ? '1 : aim[31:0];
      end
      2: faults = $urandom;
      default: faults = 32'($urandom_range(0, 3000));
    endcase
    ws = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 5000));
    case ($urandom_range(0, 2))
      0: mapped = ws;
      1: mapped = near32(ws);
      default: mapped = $urandom;
    endcase
    case ($urandom_range(0, 2))
      0: wmin = near32(ws);
      1: wmin = '0;
      default: wmin = $urandom;
    endcase
    case ($urandom_range(0, 2))
      0: wmax = near32(ws);
      1: wmax = '1;
      default: wmax = $urandom;
    endcase
    case ($urandom_range(0, 2))
      0: free_now = near32(sb.low_water);
      1: free_now = near32(sb.high_water);
      default: free_now = $urandom;
    endcase
    return start_item(mapped, faults, el, ws, wmin, wmax, free_now);
  endfunction

  // page beat weighted towards frames that the policy acts on
  function automatic wspr_in_t rand_page();
    logic [2:0] st;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: st = ST_ACTIVE;
      4: st = ST_INACTIVE;
      5: st = $urandom_range(0, 1) ? ST_MODIFIED : ST_MODIFIED_TEMP;
      default: st = 3'($urandom_range(0, 7));
    endcase
    return page_item(4'($urandom_range(0, 15)), st, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned npages;
    int unsigned span;
    wspr_in_t    it;
    bit          held;
    sb   = new();
    held = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, registers at their reset values ----
    // page beat before any scan is open: ignored
    offer(page_item(4'b0001, ST_ACTIVE, 1'b1, 1'b0));
    // short elapsed time, no free pages: trimming starts, target is mapped minus working set
    offer(start_item(32'd1000, 32'd0, 48'd5, 32'd100, 32'd50, 32'd200, 32'd0));
    // unaccessed active page, last reference: unmapped, goes inactive, target drops
    offer(page_item(4'b0001, ST_ACTIVE, 1'b1, 1'b0));
    // modified seen on requery after unmap, temporary cache
    offer(page_item(4'b1001, ST_ACTIVE, 1'b0, 1'b1));
    // accessed page: accessed bit cleared
    offer(page_item(4'b0011, ST_ACTIVE, 1'b1, 1'b0));
    // modified inactive page
    offer(page_item(4'b0101, ST_INACTIVE, 1'b0, 1'b0));
    // skipped pages: not present, no frame, busy, wired, unused code
    offer(page_item(4'b0110, ST_ACTIVE, 1'b1, 1'b0));
    offer(page_item(4'b1111, ST_NONE, 1'b1, 1'b0));
    offer(page_item(4'b1111, ST_BUSY, 1'b1, 1'b0));
    offer(page_item(4'b1111, ST_WIRED, 1'b1, 1'b0));
    offer(page_item(4'b1111, ST_UNUSED, 1'b1, 1'b0));
    offer(page_item(4'b0111, ST_MODIFIED, 1'b1, 1'b1));
    offer(page_item(4'b1101, ST_MODIFIED_TEMP, 1'b0, 1'b0));
    // high fault rate: grow; plenty free, trimming stops
    offer(start_item(32'd5000, 32'd5000, 48'd2000000, 32'd1000, 32'd10, 32'd4000, 32'd20000));
    // no target: nothing unmapped, modified bit still moves the state
    offer(page_item(4'b0101, ST_ACTIVE, 1'b1, 1'b1));
    // low fault rate: shrink, difference floors at zero
    offer(start_item(32'd5, 32'd10, 48'd2000000, 32'd10, 32'd0, 32'd100, 32'd10000));
    // grow past the top: sum saturates
    offer(start_item('1, '1, 48'd2000000, 32'hFFFF_FFF0, 32'd0, '1, 32'd0));
    // largest elapsed time and fault count
    offer(start_item(32'd0, '1, '1, '1, 32'd0, '1, '1));

    // zero interval, huge steps, fault rate quotient saturates
    program_policy('1, '1, '0, '0, '0, '1, '1, 16'd2);
    offer(start_item(32'd100, '1, 48'd1, 32'd5, 32'd0, 32'd10, 32'd0));
    // zero elapsed never passes the interval
    offer(start_item(32'd100, 32'd7, 48'd0, 32'd5, 32'd0, 32'd10, 32'd0));
    // quantum of two: second page ends the scan, third is ignored
    offer(page_item(4'b0001, ST_ACTIVE, 1'b1, 1'b0));
    offer(page_item(4'b0001, ST_ACTIVE, 1'b1, 1'b0));
    offer(page_item(4'b0001, ST_ACTIVE, 1'b1, 1'b0));
    // zero quantum: scan opens already done
    program_policy(32'd8192, 32'd16384, 48'd1000000, 32'd1000, 32'd100, 32'd16, 32'd16, 16'd0);
    offer(start_item(32'd100, 32'd0, 48'd1, 32'd5, 32'd0, 32'd10, 32'd0));
    offer(page_item(4'b0001, ST_ACTIVE, 1'b1, 1'b0));

    // ---- random phases, one register setting each ----
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: program_policy(32'd8192, 32'd16384, 48'd1000000, 32'd1000, 32'd100, 32'd16, 32'd16,
                          16'($urandom_range(1, 16)));
        1: program_policy('0, '1, '0, $urandom, $urandom, '1, '1, 16'd1);
        2: program_policy($urandom, $urandom, 48'($urandom_range(0, 1 << 20)), 32'd1000,
                          32'd100, 32'($urandom_range(0, 64)), 32'($urandom_range(0, 64)),
                          16'hFFFF);
        3: program_policy('1, '0, '1, 32'd1000, 32'd100, 32'd16, 32'd16,
                          16'($urandom_range(1, 32)));
        4: program_policy($urandom, $urandom, rand48(), $urandom, $urandom, $urandom, $urandom,
                          16'($urandom_range(1, 16)));
        default: program_policy(32'd8192, 32'd16384, 48'd1000000, 32'd1000, 32'd100, 32'd16,
                                32'd16, 16'd8);
      endcase
      // last phase runs flat out on both sides
      quiet = (phase == NumPhases - 1);
      sent  = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any beat at all, or a stray page
          it = $urandom_range(0, 1) ? rand_bits() : rand_page();
          if (it.mode == MODE_START || sb.quantum_left != 0) sent++;
          offer(it);
        end else begin
          // a scan: start beat then a run of pages, sometimes past the quantum
          offer(rand_start());
          sent++;
          span   = (sb.scan_quantum > 24) ? 24 : sb.scan_quantum;
          npages = $urandom_range(0, span + 2);
          repeat (npages) begin
            if (sb.quantum_left != 0) sent++;
            offer(rand_page());
          end
        end
        // one long hold-off mid phase while beats keep coming
        if (phase == 2 && !held && sent >= PhaseItems / 2) begin
          hold_off_req = 1'b1;
          held         = 1'b1;
        end
      end
    end

    settle();
    repeat (DrainCycles) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("results still expected at end", sb.pending(), '0);
    if (sb.n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
